// ----- hdl/buzzer_pattern_sequencer_unit_macros.svh -----
// Assertion helpers for the sequencer top-level file.
`ifndef BUZZER_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of aclk outside reset.
`define BPS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("buzzer sequencer check failed");

// Next-cycle implication.
`define BPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("buzzer sequencer check failed");

`endif

// ----- hdl/bps_pkg.sv -----
`default_nettype none

package bps_pkg;

    localparam int OP_W   = 2;
    localparam int PAT_W  = 3;
    localparam int FREQ_W = 20;
    localparam int MS_W   = 10;
    localparam int IDX_W  = 5;
    localparam int UA_W   = 4;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY     = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_FREQ = 2'd3;

    // Pattern codes.
    localparam logic [PAT_W-1:0] PAT_SINGLE     = 3'd0;
    localparam logic [PAT_W-1:0] PAT_DOUBLE     = 3'd1;
    localparam logic [PAT_W-1:0] PAT_CONTINUOUS = 3'd2;
    localparam logic [PAT_W-1:0] PAT_SOS        = 3'd3;
    localparam logic [PAT_W-1:0] PAT_ALERT      = 3'd4;
    localparam logic [PAT_W-1:0] PAT_COUNT      = 3'd5;

    localparam int unsigned PERIOD_NUMERATOR = 1000000;
    localparam int unsigned DEFAULT_HZ       = 2000;
    localparam int unsigned ALERT_HIGH_HZ    = 2000;
    localparam int unsigned ALERT_LOW_HZ     = 1500;

    localparam logic [FREQ_W-1:0] PERIOD_NUM        = FREQ_W'(PERIOD_NUMERATOR);
    localparam logic [FREQ_W-1:0] DEFAULT_PERIOD    = FREQ_W'(PERIOD_NUMERATOR / DEFAULT_HZ);
    localparam logic [FREQ_W-1:0] ALERT_HIGH_PERIOD = FREQ_W'(PERIOD_NUMERATOR / ALERT_HIGH_HZ);
    localparam logic [FREQ_W-1:0] ALERT_LOW_PERIOD  = FREQ_W'(PERIOD_NUMERATOR / ALERT_LOW_HZ);

    localparam logic [MS_W-1:0] MS_100 = 10'd100;
    localparam logic [MS_W-1:0] MS_200 = 10'd200;
    localparam logic [MS_W-1:0] MS_300 = 10'd300;
    localparam logic [MS_W-1:0] MS_400 = 10'd400;
    localparam logic [MS_W-1:0] MS_600 = 10'd600;

    typedef enum logic [1:0] {
        FSEL_KEEP,
        FSEL_HIGH,
        FSEL_LOW
    } fsel_t;

    typedef struct packed {
        logic            valid;
        logic            on;
        logic [MS_W-1:0] ms;
        fsel_t           fsel;
    } step_t;

    // Micro-operations that the control word hands to the datapath.
    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_EMIT,
        U_TICK,
        U_LOAD,
        U_PLAY,
        U_STOP,
        U_SETF,
        U_DIV,
        U_DIVW
    } uop_t;

    // Next-address selection.
    typedef enum logic [2:0] {
        C_STEP,      // fall through
        C_GOTO,      // unconditional jump
        C_DISPATCH,  // on flag jump by operation, else hold
        C_WAIT,      // on flag jump, else hold
        C_BRANCH     // on flag jump, else fall through
    } cond_t;

    typedef logic [UA_W-1:0] uaddr_t;

    localparam uaddr_t A_FETCH = 4'd0;
    localparam uaddr_t A_EMIT  = 4'd1;
    localparam uaddr_t A_TICK  = 4'd2;
    localparam uaddr_t A_LOAD  = 4'd3;
    localparam uaddr_t A_PLAY  = 4'd4;
    localparam uaddr_t A_RET   = 4'd5;
    localparam uaddr_t A_STOP  = 4'd6;
    localparam uaddr_t A_SETF  = 4'd7;
    localparam uaddr_t A_DIV   = 4'd8;
    localparam uaddr_t A_DIVW  = 4'd9;

    typedef struct packed {
        uop_t   uop;
        cond_t  cond;
        uaddr_t target;
    } ucode_t;

    // The microprogram.
    function automatic ucode_t urom(input uaddr_t addr);
        ucode_t w;
        unique case (addr)
            A_FETCH: w = '{uop: U_FETCH, cond: C_DISPATCH, target: A_FETCH};
            A_EMIT:  w = '{uop: U_EMIT,  cond: C_WAIT,     target: A_FETCH};
            A_TICK:  w = '{uop: U_TICK,  cond: C_BRANCH,   target: A_EMIT};
            A_LOAD:  w = '{uop: U_LOAD,  cond: C_GOTO,     target: A_EMIT};
            A_PLAY:  w = '{uop: U_PLAY,  cond: C_BRANCH,   target: A_LOAD};
            A_RET:   w = '{uop: U_NOP,   cond: C_GOTO,     target: A_EMIT};
            A_STOP:  w = '{uop: U_STOP,  cond: C_GOTO,     target: A_EMIT};
            A_SETF:  w = '{uop: U_SETF,  cond: C_BRANCH,   target: A_EMIT};
            A_DIV:   w = '{uop: U_DIV,   cond: C_BRANCH,   target: A_DIV};
            A_DIVW:  w = '{uop: U_DIVW,  cond: C_GOTO,     target: A_EMIT};
            default: w = '{uop: U_NOP,   cond: C_GOTO,     target: A_FETCH};
        endcase
        return w;
    endfunction

    function automatic uaddr_t dispatch(input logic [OP_W-1:0] op);
        uaddr_t a;
        unique case (op)
            OP_TICK:     a = A_TICK;
            OP_PLAY:     a = A_PLAY;
            OP_STOP:     a = A_STOP;
            OP_SET_FREQ: a = A_SETF;
            default:     a = A_FETCH;
        endcase
        return a;
    endfunction

    // Pattern step table. Steps past the end of a pattern come back invalid.
    function automatic step_t pattern_step(input logic [PAT_W-1:0] pat,
                                           input logic [IDX_W-1:0] idx);
        step_t s;
        logic  sos_first;
        logic  sos_long;
        logic  sos_last;
        s         = '{valid: 1'b0, on: 1'b0, ms: '0, fsel: FSEL_KEEP};
        sos_first = (idx < 5'd6);
        sos_long  = (idx >= 5'd7) && (idx <= 5'd12);
        sos_last  = (idx >= 5'd14) && (idx <= 5'd19);
        unique case (pat)
            PAT_SINGLE: begin
                if (idx == 5'd0) begin
                    s = '{valid: 1'b1, on: 1'b1, ms: MS_200, fsel: FSEL_KEEP};
                end
            end
            PAT_DOUBLE: begin
                if (idx == 5'd1) begin
                    s = '{valid: 1'b1, on: 1'b0, ms: MS_100, fsel: FSEL_KEEP};
                end else if (idx == 5'd0 || idx == 5'd2) begin
                    s = '{valid: 1'b1, on: 1'b1, ms: MS_200, fsel: FSEL_KEEP};
                end
            end
            PAT_SOS: begin
                if (idx < 5'd20) begin
                    s.valid = 1'b1;
                    s.on    = ((sos_first || sos_last) && !idx[0]) || (sos_long && idx[0]);
                    if (idx == 5'd6 || idx == 5'd13) begin
                        s.ms = MS_400;
                    end else if (sos_long && idx[0]) begin
                        s.ms = MS_600;
                    end else begin
                        s.ms = MS_200;
                    end
                end
            end
            PAT_ALERT: begin
                if (idx < 5'd6) begin
                    s = '{valid: 1'b1, on: 1'b1, ms: MS_300,
                          fsel: (idx[0] ? FSEL_LOW : FSEL_HIGH)};
                end
            end
            default: ;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/buzzer_pattern_sequencer_unit.sv -----
`default_nettype none

`include "buzzer_pattern_sequencer_unit_macros.svh"

// Buzzer pattern sequencer. Each input transfer carries one operation (a
// one-millisecond tick, play a pattern, stop, or set the tone frequency) and
// produces exactly one result transfer with the tone on/off state, the PWM
// period in microseconds (1000000 / frequency, 50 percent duty), the busy flag
// and an accept/reject status. Items are handled one at a time by a small
// microprogram, which accepts the transfer in its fetch step. A tick then goes
// through the tick and emit steps, with a load step before the emit when the
// current step runs out; a play through play, load (or return) and emit; a stop
// through stop and emit; a set frequency through set frequency, the 20 steps of
// the bit-serial period divider, the write-back and emit, or straight to emit
// when refused. Emit loads the result into the output register and returns to
// fetch. A finished result waits there while the next item is accepted, so a
// slow result consumer only stalls the block once a second result is ready.
// The period resets to 500 us (2000 Hz); the alert pattern retunes it between
// 500 us and 666 us and leaves it at 666 us.

module buzzer_pattern_sequencer_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bps_pkg::OP_W-1:0]     s_operation,
    input  wire logic [bps_pkg::PAT_W-1:0]    s_pattern,
    input  wire logic [bps_pkg::FREQ_W-1:0]   s_frequency_hz,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_tone_on,
    output logic      [bps_pkg::FREQ_W-1:0]   m_tone_period_us,
    output logic                              m_busy_res,
    output logic                              m_status
);
    import bps_pkg::*;

    // Current control word and the datapath condition that steers the jumps.
    ucode_t cw;
    logic   flag;

    // The sequencer dispatches straight on the operation field of the
    // transfer being accepted; the datapath latches the other fields.
    bps_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flag    (flag),
        .op      (s_operation),
        .cw      (cw)
    );

    bps_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .uop              (cw.uop),
        .flag             (flag),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pattern        (s_pattern),
        .s_frequency_hz   (s_frequency_hz),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tone_on        (m_tone_on),
        .m_tone_period_us (m_tone_period_us),
        .m_busy_res       (m_busy_res),
        .m_status         (m_status)
    );

    // Only one item is in flight: acceptance leaves the fetch step at once.
    `BPS_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    // The tone is only driven while a pattern is playing.
    `BPS_ASSERT_IMPL(a_tone_needs_busy, m_valid && m_tone_on, m_busy_res)
    // A valid frequency never yields a zero period.
    `BPS_ASSERT_IMPL(a_period_nonzero, m_valid, m_tone_period_us != '0)

endmodule

`default_nettype wire

// ----- hdl/bps_useq.sv -----
`default_nettype none

module bps_useq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       flag,
    input  wire logic [bps_pkg::OP_W-1:0]   op,
    output bps_pkg::ucode_t                 cw
);
    import bps_pkg::*;

    uaddr_t upc_reg;
    uaddr_t upc_next;

    assign cw = urom(upc_reg);

    always_comb begin
        unique case (cw.cond)
            C_STEP:     upc_next = upc_reg + 1'b1;
            C_GOTO:     upc_next = cw.target;
            C_DISPATCH: upc_next = flag ? dispatch(op) : upc_reg;
            C_WAIT:     upc_next = flag ? cw.target : upc_reg;
            C_BRANCH:   upc_next = flag ? cw.target : upc_reg + 1'b1;
            default:    upc_next = A_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bps_divider.sv -----
`default_nettype none

module bps_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic                         step,
    input  wire logic [bps_pkg::FREQ_W-1:0]   divisor,
    output logic      [bps_pkg::FREQ_W-1:0]   quotient,
    output logic                              last
);
    import bps_pkg::*;

    // Restoring division of the fixed numerator, one quotient bit per step.
    localparam logic [IDX_W-1:0] FIRST_BIT = IDX_W'(FREQ_W - 1);

    logic [IDX_W-1:0]  count_reg,   count_next;
    logic [FREQ_W-1:0] rem_reg,     rem_next;
    logic [FREQ_W-1:0] quo_reg,     quo_next;
    logic [FREQ_W-1:0] div_reg,     div_next;
    logic [FREQ_W:0]   rem_shift;
    logic [FREQ_W:0]   rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg, PERIOD_NUM[count_reg]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});
    assign last      = (count_reg == '0);
    assign quotient  = quo_reg;

    always_comb begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (start) begin
            count_next = FIRST_BIT;
            rem_next   = '0;
            div_next   = divisor;
        end else if (step) begin
            rem_next = fits ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
            quo_next = {quo_reg[FREQ_W-2:0], fits};
            if (!last) begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

`default_nettype wire

// ----- hdl/bps_datapath.sv -----
`default_nettype none

module bps_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bps_pkg::uop_t                uop,
    output logic                              flag,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bps_pkg::PAT_W-1:0]    s_pattern,
    input  wire logic [bps_pkg::FREQ_W-1:0]   s_frequency_hz,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_tone_on,
    output logic      [bps_pkg::FREQ_W-1:0]   m_tone_period_us,
    output logic                              m_busy_res,
    output logic                              m_status
);
    import bps_pkg::*;

    logic [PAT_W-1:0]  pat_reg,     pat_next;
    logic [FREQ_W-1:0] freq_reg,    freq_next;
    logic              playing_reg, playing_next;
    logic [PAT_W-1:0]  act_reg,     act_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [MS_W-1:0]   ms_left_reg, ms_left_next;
    logic [FREQ_W-1:0] period_reg,  period_next;
    logic              tone_reg,    tone_next;
    logic              status_reg,  status_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_tone_reg,  m_tone_next;
    logic [FREQ_W-1:0] m_period_reg, m_period_next;
    logic              m_busy_reg,  m_busy_next;
    logic              m_status_reg, m_status_next;

    step_t             step;
    logic              counting;
    logic              need_load;
    logic              play_reject;
    logic              play_load;
    logic              freq_bad;
    logic              slot_free;
    logic [FREQ_W-1:0] quotient;
    logic              div_last;

    bps_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (uop == U_SETF),
        .step     (uop == U_DIV),
        .divisor  (freq_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    assign step        = pattern_step(act_reg, idx_reg);
    assign counting    = playing_reg && (act_reg != PAT_CONTINUOUS);
    assign need_load   = counting && (ms_left_reg < 10'd2);
    assign play_reject = playing_reg || (pat_reg >= PAT_COUNT);
    assign play_load   = !play_reject && (pat_reg != PAT_CONTINUOUS);
    assign freq_bad    = (freq_reg == '0) || (freq_reg > PERIOD_NUM);
    assign slot_free   = !m_valid_reg || m_ready;
    assign s_ready     = (uop == U_FETCH);

    always_comb begin
        unique case (uop)
            U_FETCH: flag = s_valid;
            U_EMIT:  flag = slot_free;
            U_TICK:  flag = !need_load;
            U_PLAY:  flag = play_load;
            U_SETF:  flag = freq_bad;
            U_DIV:   flag = !div_last;
            default: flag = 1'b0;
        endcase
    end

    always_comb begin
        pat_next      = pat_reg;
        freq_next     = freq_reg;
        playing_next  = playing_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        ms_left_next  = ms_left_reg;
        period_next   = period_reg;
        tone_next     = tone_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_tone_next   = m_tone_reg;
        m_period_next = m_period_reg;
        m_busy_next   = m_busy_reg;
        m_status_next = m_status_reg;
        unique case (uop)
            U_FETCH: begin
                if (s_valid) begin
                    pat_next  = s_pattern;
                    freq_next = s_frequency_hz;
                end
            end
            U_TICK: begin
                status_next = 1'b0;
                if (counting) begin
                    if (need_load) begin
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        ms_left_next = ms_left_reg - 1'b1;
                    end
                end
            end
            U_LOAD: begin
                if (step.valid) begin
                    tone_next    = step.on;
                    ms_left_next = step.ms;
                    if (step.fsel == FSEL_HIGH) begin
                        period_next = ALERT_HIGH_PERIOD;
                    end else if (step.fsel == FSEL_LOW) begin
                        period_next = ALERT_LOW_PERIOD;
                    end
                end else begin
                    playing_next = 1'b0;
                    act_next     = '0;
                    idx_next     = '0;
                    ms_left_next = '0;
                    tone_next    = 1'b0;
                end
            end
            U_PLAY: begin
                status_next = play_reject;
                if (!play_reject) begin
                    playing_next = 1'b1;
                    act_next     = pat_reg;
                    idx_next     = '0;
                    if (pat_reg == PAT_CONTINUOUS) begin
                        tone_next    = 1'b1;
                        ms_left_next = '0;
                    end
                end
            end
            U_STOP: begin
                status_next  = 1'b0;
                playing_next = 1'b0;
                act_next     = '0;
                idx_next     = '0;
                ms_left_next = '0;
                tone_next    = 1'b0;
            end
            U_SETF: begin
                status_next = freq_bad;
            end
            U_DIVW: begin
                period_next = quotient;
            end
            U_EMIT: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_tone_next   = tone_reg;
                    m_period_next = period_reg;
                    m_busy_next   = playing_reg;
                    m_status_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= 1'b0;
            act_reg     <= '0;
            idx_reg     <= '0;
            ms_left_reg <= '0;
            period_reg  <= DEFAULT_PERIOD;
            tone_reg    <= 1'b0;
            status_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            playing_reg <= playing_next;
            act_reg     <= act_next;
            idx_reg     <= idx_next;
            ms_left_reg <= ms_left_next;
            period_reg  <= period_next;
            tone_reg    <= tone_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg      <= pat_next;
        freq_reg     <= freq_next;
        m_tone_reg   <= m_tone_next;
        m_period_reg <= m_period_next;
        m_busy_reg   <= m_busy_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_tone_on        = m_tone_reg;
    assign m_tone_period_us = m_period_reg;
    assign m_busy_res       = m_busy_reg;
    assign m_status         = m_status_reg;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the buzzer pattern sequencer.
//
// Every input transfer carries one operation and produces exactly one result
// transfer. A behavioral model of the sequencer lives in this module. It keeps
// its own copy of the playing flag, the pattern position, the step countdown,
// the tone frequency and the PWM period. At every accepted input it computes the
// result that the block must give and queues it. A separate process pops that
// queue at every accepted result and compares the four fields.
//
// The run is split into three idling phases. In the first the sender idles
// often and the receiver very often. In the second the rates are swapped. In
// the third neither side idles. Directed tests come first: the idle tick,
// frequency limits, rejected plays, and the continuous pattern. Random traffic
// follows, and then walks through the single pattern to its end and through
// the alert pattern past its first change of tone.
module tb_top;

    import bps_pkg::*;

    // Generous ceiling for every item of the run, even with every stall
    // stretched to its worst.
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned HOLD_CYCLES   = 300;
    // The span of a walk is capped at this, which still reaches the first
    // tone change of the alert pattern.
    localparam int unsigned WALK_MAX_MS   = 310;

    // The SOS pattern has twenty steps. Bit n of each mask describes step n:
    // whether the tone sounds, whether it is a long mark (600 ms), and whether
    // it is a letter gap (400 ms). Every other step lasts 200 ms.
    localparam logic [19:0] SOS_ON_MASK   = 20'h54A95;
    localparam logic [19:0] SOS_LONG_MASK = 20'h00A80;
    localparam logic [19:0] SOS_GAP_MASK  = 20'h02040;

    typedef struct packed {
        logic              tone_on;
        logic [FREQ_W-1:0] period_us;
        logic              busy;
        logic              status;
    } buzzer_result_t;

    typedef struct packed {
        logic            valid;
        logic            on;
        logic [MS_W-1:0] dur;
        fsel_t           fsel;
    } tone_step_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation    = OP_TICK;
    logic [PAT_W-1:0]    s_pattern      = PAT_SINGLE;
    logic [FREQ_W-1:0]   s_frequency_hz = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_tone_on;
    logic [FREQ_W-1:0]   m_tone_period_us;
    logic                m_busy_res;
    logic                m_status;

    // State of the model. It mirrors the sequencer registers at the same widths.
    logic                seq_playing;
    logic [PAT_W-1:0]    seq_pattern;
    logic [IDX_W-1:0]    seq_step;
    logic [MS_W-1:0]     seq_ms_left;
    logic [FREQ_W-1:0]   seq_freq;
    logic [FREQ_W-1:0]   seq_period;
    logic                seq_tone;

    buzzer_result_t      pending_results[$];
    int unsigned         items_sent    = 0;
    int unsigned         error_count   = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         tx_idle_pct   = 0;
    int unsigned         rx_idle_pct   = 0;
    bit                  hold_request  = 1'b0;
    int unsigned         hold_left     = 0;

    buzzer_pattern_sequencer_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_pattern        (s_pattern),
        .s_frequency_hz   (s_frequency_hz),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tone_on        (m_tone_on),
        .m_tone_period_us (m_tone_period_us),
        .m_busy_res       (m_busy_res),
        .m_status         (m_status)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // -------------------------------------------------------------------------
    // Model of the sequencer
    // -------------------------------------------------------------------------

    // Returns one step of a pattern. A step past the end of the pattern comes
    // back with valid low. The continuous pattern has no steps at all.
    function automatic tone_step_t lookup_tone_step(input logic [PAT_W-1:0] pat,
                                                    input logic [IDX_W-1:0] idx);
        tone_step_t s;
        s.valid = 1'b0;
        s.on    = 1'b0;
        s.dur   = '0;
        s.fsel  = FSEL_KEEP;
        case (pat)
            PAT_SINGLE: begin
                if (idx == 0) begin
                    s.valid = 1'b1;
                    s.on    = 1'b1;
                    s.dur   = MS_200;
                end
            end
            PAT_DOUBLE: begin
                if (idx < 3) begin
                    s.valid = 1'b1;
                    s.on    = (idx != 1);
                    s.dur   = (idx == 1) ? MS_100 : MS_200;
                end
            end
            PAT_SOS: begin
                if (idx < 20) begin
                    s.valid = 1'b1;
                    s.on    = SOS_ON_MASK[idx];
                    s.dur   = SOS_LONG_MASK[idx] ? MS_600 :
                              SOS_GAP_MASK[idx]  ? MS_400 : MS_200;
                end
            end
            PAT_ALERT: begin
                // The alert alternates between the high and low tones and
                // retunes the PWM at the start of each step.
                if (idx < 6) begin
                    s.valid = 1'b1;
                    s.on    = 1'b1;
                    s.dur   = MS_300;
                    s.fsel  = idx[0] ? FSEL_LOW : FSEL_HIGH;
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic int unsigned pattern_length_ms(input logic [PAT_W-1:0] pat);
        int unsigned total;
        tone_step_t  s;
        total = 0;
        for (int i = 0; i < 32; i++) begin
            s = lookup_tone_step(pat, IDX_W'(i));
            if (s.valid) total += s.dur;
        end
        return total;
    endfunction

    function automatic void retune(input logic [FREQ_W-1:0] f);
        seq_freq   = f;
        seq_period = FREQ_W'(PERIOD_NUMERATOR / f);
    endfunction

    // A stop keeps the frequency and the period. Everything else is cleared.
    function automatic void go_quiet();
        seq_playing = 1'b0;
        seq_pattern = PAT_SINGLE;
        seq_step    = '0;
        seq_ms_left = '0;
        seq_tone    = 1'b0;
    endfunction

    function automatic void enter_step();
        tone_step_t s;
        s = lookup_tone_step(seq_pattern, seq_step);
        if (!s.valid) begin
            go_quiet();
        end else begin
            seq_tone    = s.on;
            seq_ms_left = s.dur;
            if (s.fsel == FSEL_HIGH) begin
                retune(FREQ_W'(ALERT_HIGH_HZ));
            end else if (s.fsel == FSEL_LOW) begin
                retune(FREQ_W'(ALERT_LOW_HZ));
            end
        end
    endfunction

    // Applies one accepted input to the model and returns the result it causes.
    function automatic buzzer_result_t buzzer_predict(input logic [OP_W-1:0]   op,
                                                      input logic [PAT_W-1:0]  pat,
                                                      input logic [FREQ_W-1:0] freq);
        buzzer_result_t r;
        logic           rejected;
        rejected = 1'b0;
        case (op)
            OP_TICK: begin
                // A step loaded with length d ends on its d-th tick.
                if (seq_playing && seq_pattern != PAT_CONTINUOUS) begin
                    if (seq_ms_left > 1) begin
                        seq_ms_left = seq_ms_left - 1'b1;
                    end else begin
                        seq_step = seq_step + 1'b1;
                        enter_step();
                    end
                end
            end
            OP_PLAY: begin
                if (seq_playing || pat >= PAT_COUNT) begin
                    rejected = 1'b1;
                end else begin
                    seq_playing = 1'b1;
                    seq_pattern = pat;
                    seq_step    = '0;
                    if (pat == PAT_CONTINUOUS) begin
                        seq_tone    = 1'b1;
                        seq_ms_left = '0;
                    end else begin
                        enter_step();
                    end
                end
            end
            OP_STOP: begin
                go_quiet();
            end
            default: begin
                if (freq == 0 || freq > PERIOD_NUMERATOR) begin
                    rejected = 1'b1;
                end else begin
                    retune(freq);
                end
            end
        endcase
        r.tone_on   = seq_tone;
        r.period_us = seq_period;
        r.busy      = seq_playing;
        r.status    = rejected;
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Input side
    // -------------------------------------------------------------------------

    // Offers one item and returns at the edge where it is accepted. Valid stays
    // high after the transfer so that back-to-back items need no gap. Only the
    // next idle cycle, or drop_valid, takes it low again.
    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [PAT_W-1:0]  pat,
                             input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_pattern      <= pat;
        s_frequency_hz <= freq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        pending_results.push_back(buzzer_predict(op, pat, freq));
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        drop_valid();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Frequencies from all corners: any 20-bit value (so every bit toggles and
    // the values above the limit show up), the legal range, low audio values,
    // and zero, one and two.
    function automatic logic [FREQ_W-1:0] random_frequency();
        case ($urandom_range(3))
            0:       return FREQ_W'($urandom);
            1:       return FREQ_W'($urandom_range(1, PERIOD_NUMERATOR));
            2:       return FREQ_W'($urandom_range(1, 5000));
            default: return FREQ_W'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_random_item();
        send_item(OP_W'($urandom), PAT_W'($urandom), random_frequency());
    endtask

    // -------------------------------------------------------------------------
    // Output side
    // -------------------------------------------------------------------------

    // The receiver either follows its idle rate or, on request, holds ready
    // low for a long stretch. The stretch is counted here.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        buzzer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no item outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("tone_on", want.tone_on, m_tone_on);
                check_field("tone_period_us", want.period_us, m_tone_period_us);
                check_field("busy_res", want.busy, m_busy_res);
                check_field("status", want.status, m_status);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------

    // Ticks while idle change nothing. The period still shows the reset tone.
    task automatic test_idle_tick();
        send_item(OP_TICK, PAT_SINGLE, '0);
        send_item(OP_TICK, PAT_W'(7), FREQ_W'(20'hFFFFF));
    endtask

    // Zero and anything above one megahertz are refused. One hertz gives the
    // widest period, and one megahertz gives a period of one microsecond.
    task automatic test_frequency_limits();
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(0));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(1));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(PERIOD_NUMERATOR));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(PERIOD_NUMERATOR + 1));
        send_item(OP_SET_FREQ, PAT_W'(7), FREQ_W'(20'hFFFFF));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(3));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(DEFAULT_HZ));
    endtask

    // Unknown pattern codes are refused, and so is a play while one is running.
    // A stop is accepted whether or not anything is playing.
    task automatic test_play_rejects();
        send_item(OP_PLAY, PAT_W'(5), '0);
        send_item(OP_PLAY, PAT_W'(6), '0);
        send_item(OP_PLAY, PAT_W'(7), '0);
        send_item(OP_PLAY, PAT_SINGLE, '0);
        send_item(OP_PLAY, PAT_DOUBLE, '0);
        send_item(OP_STOP, PAT_SINGLE, '0);
        send_item(OP_STOP, PAT_SINGLE, '0);
    endtask

    // The continuous tone ignores ticks. A retune while it is busy takes effect
    // at once. A bad frequency is still refused while busy.
    task automatic test_continuous();
        send_item(OP_PLAY, PAT_CONTINUOUS, '0);
        send_item(OP_TICK, PAT_SINGLE, '0);
        send_item(OP_TICK, PAT_SINGLE, '0);
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(1234));
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(0));
        send_item(OP_PLAY, PAT_SOS, '0);
        send_item(OP_STOP, PAT_SINGLE, '0);
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(DEFAULT_HZ));
    endtask

    // Most sequences are well formed: a play followed by a run of ticks, with
    // stray items mixed in and often a stop at the end. Short runs stay inside
    // the first step. Long runs can cross step boundaries, and the single
    // pattern can run out during them.
    task automatic test_random_traffic(input int unsigned budget);
        int unsigned      stop_at;
        int unsigned      ticks;
        logic [PAT_W-1:0] pat;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                pat = ($urandom_range(9) == 0) ? PAT_W'($urandom_range(5, 7))
                                               : PAT_W'($urandom_range(0, 4));
                send_item(OP_PLAY, pat, random_frequency());
                ticks = ($urandom_range(4) == 0) ? $urandom_range(180, 320)
                                                 : $urandom_range(1, 30);
                repeat (ticks) begin
                    if ($urandom_range(99) < 4) begin
                        send_random_item();
                    end else begin
                        send_item(OP_TICK, PAT_W'($urandom), random_frequency());
                    end
                end
                if ($urandom_range(1) == 1) begin
                    send_item(OP_STOP, PAT_W'($urandom), random_frequency());
                end
            end else begin
                send_random_item();
            end
        end
    endtask

    // The sender stops offering until every outstanding result has come back.
    // Then it picks up again in the middle of a running pattern.
    task automatic test_sender_pause();
        send_item(OP_PLAY, PAT_DOUBLE, '0);
        repeat (5) send_item(OP_TICK, PAT_SINGLE, '0);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        repeat (5) send_item(OP_TICK, PAT_SINGLE, '0);
        send_item(OP_STOP, PAT_SINGLE, '0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering. The output register fills, and the block must stall its input
    // without losing or reordering anything.
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (12) begin
            if ($urandom_range(1) == 1) begin
                send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'($urandom_range(1, 20000)));
            end else begin
                send_item(OP_TICK, PAT_SINGLE, '0);
            end
        end
        wait_for_results();
        send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(DEFAULT_HZ));
    endtask

    // The single pattern is played to its natural end and a little past it.
    // The alert pattern is played until just past its first change of tone
    // and then stopped. Halfway through, a retune and a refused play are
    // inserted. In the alert pattern the next step overrides that retune.
    task automatic test_pattern_walks();
        logic [PAT_W-1:0] walk [2];
        int unsigned      span;
        int unsigned      t;
        walk = '{PAT_SINGLE, PAT_ALERT};
        foreach (walk[w]) begin
            span = pattern_length_ms(walk[w]);
            if (span > WALK_MAX_MS) begin
                span = WALK_MAX_MS;
            end
            send_item(OP_PLAY, walk[w], '0);
            for (t = 0; t < span + 2; t++) begin
                if (t == span / 2) begin
                    send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(4000));
                    send_item(OP_PLAY, PAT_SINGLE, '0);
                end
                send_item(OP_TICK, PAT_SINGLE, '0);
            end
            send_item(OP_STOP, PAT_SINGLE, '0);
            send_item(OP_SET_FREQ, PAT_SINGLE, FREQ_W'(DEFAULT_HZ));
        end
    endtask

    initial begin
        go_quiet();
        retune(FREQ_W'(DEFAULT_HZ));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: the sender idles now and then, and the receiver is mostly slow.
        tx_idle_pct = 32;
        rx_idle_pct = 73;
        test_idle_tick();
        test_frequency_limits();
        test_play_rejects();
        test_continuous();
        test_random_traffic(100);
        wait_for_results();

        // Phase two: the sender is slow and the receiver idles now and then.
        tx_idle_pct = 73;
        rx_idle_pct = 32;
        test_random_traffic(100);
        test_sender_pause();
        wait_for_results();

        // Phase three: both sides run at full rate.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_pattern_walks();
        test_random_traffic(100);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
